// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define MACP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// same-cycle implication
`define MACP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MACP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/macp_pkg.sv -----
`default_nettype none

package macp_pkg;

   localparam int ADDRESS_BYTES = 6;
   localparam int TEXT_LEN      = 3 * ADDRESS_BYTES - 1;
   localparam int ADDR_BITS     = 8 * ADDRESS_BYTES;
   localparam int POS_WIDTH     = $clog2(TEXT_LEN + 1);
   localparam logic [POS_WIDTH-1:0] TEXT_LEN_POS = POS_WIDTH'(TEXT_LEN);

   localparam int MAC_WIDTH        = 48;
   localparam int STATUS_WIDTH     = 3;
   localparam int REQ_TDATA_WIDTH  = 8;
   localparam int RSP_TDATA_WIDTH  = 56;
   localparam int RSP_PAD_WIDTH    = RSP_TDATA_WIDTH - MAC_WIDTH - STATUS_WIDTH;

   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_PAD_WIDTH  = CSR_DATA_WIDTH - MAC_WIDTH;

   localparam logic CSR_IDX_BLOCKED_A = 1'b0;
   localparam logic CSR_IDX_BLOCKED_B = 1'b1;

   localparam logic [MAC_WIDTH-1:0] BLOCKED_A_RESET = 48'h0000_0000_0000;
   localparam logic [MAC_WIDTH-1:0] BLOCKED_B_RESET = 48'h4444_4444_4444;

   localparam logic [7:0] CHAR_COLON  = 8'h3a;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

   localparam logic [1:0] PHASE_SEPARATOR = 2'd2;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_SEP   = 2'd1,
      ERR_DIGIT = 2'd2
   } err_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK            = 3'd0,
      STATUS_TOO_SHORT     = 3'd1,
      STATUS_BAD_SEPARATOR = 3'd2,
      STATUS_BAD_DIGIT     = 3'd3,
      STATUS_MULTICAST     = 3'd4,
      STATUS_BLOCKED       = 3'd5
   } status_type;

   typedef struct packed {
      logic [MAC_WIDTH-1:0] a;
      logic [MAC_WIDTH-1:0] b;
   } blocked_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok     = 1'b1;
      r.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.nibble = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.nibble = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/macp_csr.sv -----
`default_nettype none

module macp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [macp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [macp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [macp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output macp_pkg::blocked_type               blocked
);
   import macp_pkg::*;

   logic [MAC_WIDTH-1:0] blocked_a_ff, blocked_a_in;
   logic [MAC_WIDTH-1:0] blocked_b_ff, blocked_b_in;
   logic                 wr_en;
   logic                 reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3];

   always_comb begin
      blocked_a_in = blocked_a_ff;
      blocked_b_in = blocked_b_ff;
      if (wr_en) begin
         if (reg_idx == CSR_IDX_BLOCKED_A) begin
            blocked_a_in = csr_pwdata[MAC_WIDTH-1:0];
         end else begin
            blocked_b_in = csr_pwdata[MAC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_a_ff <= BLOCKED_A_RESET;
         blocked_b_ff <= BLOCKED_B_RESET;
      end else begin
         blocked_a_ff <= blocked_a_in;
         blocked_b_ff <= blocked_b_in;
      end
   end

   assign csr_prdata = (reg_idx == CSR_IDX_BLOCKED_B) ? {CSR_PAD_WIDTH'(0), blocked_b_ff}
                                                       : {CSR_PAD_WIDTH'(0), blocked_a_ff};
   assign blocked.a  = blocked_a_ff;
   assign blocked.b  = blocked_b_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mac_address_text_parser_unit.sv -----
// Flow: a character is registered at accept and parsed from the input register; the result
// for an end-of-string character is loaded into the output register when that character advances.
// Throughput: one character per cycle, set by the single parse stage; it stalls only
// while a finished result waits in the output register and the next string ends.
// Reset: synchronous, active high; clears the input valid, the parse state and output valid and loads
// the blocked-address registers with their defaults.
`default_nettype none
`include "assert_macros.svh"

module mac_address_text_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [macp_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,   // [7:0] character
   input  logic                                 req_tlast,   // end_of_string
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [macp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,   // [47:0] mac_address, [50:48] status
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [macp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [macp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [macp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import macp_pkg::*;

   blocked_type blocked;

   macp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .blocked     (blocked)
   );

   // input stage
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  in_eos_ff;
   logic                  advance;

   // parse state
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [1:0]            phase_ff, phase_in;
   logic [ADDR_BITS-1:0]  shift_ff, shift_in;
   err_type               fe_ff, fe_in;
   logic                  gde_ff, gde_in;

   // step results
   logic [POS_WIDTH-1:0]  pos_n;
   logic [1:0]            phase_n;
   logic [ADDR_BITS-1:0]  shift_n;
   err_type               fe_n;
   err_type               fe_final;
   logic                  gde_n;
   logic                  sep_ok;
   hex_type               dec;
   status_type            status;
   logic [MAC_WIDTH-1:0]  mac;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MAC_WIDTH-1:0]  rsp_mac_ff;
   status_type            rsp_status_ff;
   logic                  rsp_err;

   assign advance    = in_valid_ff & (~in_eos_ff | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
   end

   always_comb begin
      pos_n   = pos_ff;
      phase_n = phase_ff;
      shift_n = shift_ff;
      fe_n    = fe_ff;
      gde_n   = gde_ff;
      sep_ok  = (in_char_ff == CHAR_COLON) || (in_char_ff == CHAR_HYPHEN);
      dec     = hex_decode(in_char_ff);
      if (pos_ff < TEXT_LEN_POS) begin
         if (phase_ff == PHASE_SEPARATOR) begin
            if (fe_ff == ERR_NONE) begin
               if (!sep_ok) begin
                  fe_n = ERR_SEP;
               end else if (gde_ff) begin
                  fe_n = ERR_DIGIT;
               end
            end
            gde_n   = 1'b0;
            phase_n = 2'd0;
         end else begin
            if (!dec.ok) begin
               gde_n = 1'b1;
            end
            shift_n = {shift_ff[ADDR_BITS-5:0], dec.nibble};
            phase_n = phase_ff + 2'd1;
         end
         pos_n = pos_ff + 1'b1;
      end
   end

   always_comb begin
      fe_final = (fe_n == ERR_NONE && gde_n) ? ERR_DIGIT : fe_n;
      if (pos_n < TEXT_LEN_POS) begin
         status = STATUS_TOO_SHORT;
      end else begin
         case (fe_final)
            ERR_SEP:   status = STATUS_BAD_SEPARATOR;
            ERR_DIGIT: status = STATUS_BAD_DIGIT;
            default: begin
               if (shift_n[ADDR_BITS-8]) begin
                  status = STATUS_MULTICAST;
               end else if (shift_n == ADDR_BITS'(blocked.a) ||
                            shift_n == ADDR_BITS'(blocked.b)) begin
                  status = STATUS_BLOCKED;
               end else begin
                  status = STATUS_OK;
               end
            end
         endcase
      end
      if (status == STATUS_TOO_SHORT || status == STATUS_BAD_SEPARATOR ||
          status == STATUS_BAD_DIGIT) begin
         mac = '0;
      end else begin
         mac = shift_n[MAC_WIDTH-1:0];
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      shift_in = shift_ff;
      fe_in    = fe_ff;
      gde_in   = gde_ff;
      if (advance) begin
         if (in_eos_ff) begin
            pos_in   = '0;
            phase_in = 2'd0;
            shift_in = '0;
            fe_in    = ERR_NONE;
            gde_in   = 1'b0;
         end else begin
            pos_in   = pos_n;
            phase_in = phase_n;
            shift_in = shift_n;
            fe_in    = fe_n;
            gde_in   = gde_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= 2'd0;
         shift_ff <= '0;
         fe_ff    <= ERR_NONE;
         gde_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         fe_ff    <= fe_in;
         gde_ff   <= gde_in;
      end
   end

   assign rsp_valid_in = (advance && in_eos_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_eos_ff) begin
         rsp_mac_ff    <= mac;
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_WIDTH'(0), rsp_status_ff, rsp_mac_ff};

   assign rsp_err = (rsp_status_ff == STATUS_TOO_SHORT) ||
                    (rsp_status_ff == STATUS_BAD_SEPARATOR) ||
                    (rsp_status_ff == STATUS_BAD_DIGIT);

   `MACP_ASSERT_ALWAYS(a_pos_bound, clock, reset, pos_ff <= TEXT_LEN_POS)
   `MACP_ASSERT_ALWAYS(a_phase_bound, clock, reset, phase_ff <= PHASE_SEPARATOR)
   `MACP_ASSERT_IMPLY(a_err_zero_mac, clock, reset, rsp_valid_ff && rsp_err, rsp_mac_ff == '0)
   `MACP_ASSERT_NEXT(a_eos_result, clock, reset, advance && in_eos_ff, rsp_valid_ff && pos_ff == '0)

endmodule

`default_nettype wire

// ----- bench/mac_text_checker.sv -----
`timescale 1ns / 100ps

module mac_text_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [macp_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,   // [7:0] character
   input  logic                                 req_tlast,   // end_of_string
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [macp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,   // [47:0] mac_address, [50:48] status
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [macp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [macp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   input  logic                                 csr_pready,
   output int                                   failures,
   output int                                   pending
);
   import macp_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_BLOCKED_A = {CSR_IDX_BLOCKED_A, 3'b000};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_BLOCKED_B = {CSR_IDX_BLOCKED_B, 3'b000};

   typedef struct packed {
      logic [MAC_WIDTH-1:0] mac;
      status_type           status;
   } parsed_mac_type;

   parsed_mac_type       parsed_q[$];
   logic [POS_WIDTH-1:0] char_count;
   logic [ADDR_BITS-1:0] digits;
   err_type              first_fault;
   logic                 group_bad;
   logic [MAC_WIDTH-1:0] blocked_a;
   logic [MAC_WIDTH-1:0] blocked_b;
   int                   mismatches = 0;

   // {valid, nibble}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, 4'(c - "0")};
      end
      if (c >= "a" && c <= "f") begin
         return {1'b1, 4'(c - "a" + 8'd10)};
      end
      if (c >= "A" && c <= "F") begin
         return {1'b1, 4'(c - "A" + 8'd10)};
      end
      return 5'b0;
   endfunction

   task automatic clear_parse();
      char_count  = '0;
      digits      = '0;
      first_fault = ERR_NONE;
      group_bad   = 1'b0;
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      if (mismatches < 30) begin
         $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   task automatic take_char(input logic [7:0] c, input logic last);
      logic [4:0]           hex;
      logic [MAC_WIDTH-1:0] addr;
      parsed_mac_type       r;
      if (char_count < TEXT_LEN_POS) begin
         if (char_count % 3 == PHASE_SEPARATOR) begin
            if (first_fault == ERR_NONE) begin
               if (c != CHAR_COLON && c != CHAR_HYPHEN) begin
                  first_fault = ERR_SEP;
               end else if (group_bad) begin
                  first_fault = ERR_DIGIT;
               end
            end
            group_bad = 1'b0;
         end else begin
            hex = hex_value(c);
            if (!hex[4]) begin
               group_bad = 1'b1;
            end
            digits = {digits[ADDR_BITS-5:0], hex[3:0]};
         end
         char_count = char_count + 1'b1;
      end
      if (last) begin
         addr = digits;
         if (char_count < TEXT_LEN_POS) begin
            r.status = STATUS_TOO_SHORT;
         end else begin
            if (first_fault == ERR_NONE && group_bad) begin
               first_fault = ERR_DIGIT;
            end
            if (first_fault == ERR_SEP) begin
               r.status = STATUS_BAD_SEPARATOR;
            end else if (first_fault == ERR_DIGIT) begin
               r.status = STATUS_BAD_DIGIT;
            end else if (addr[ADDR_BITS-8]) begin
               r.status = STATUS_MULTICAST;
            end else if (addr == blocked_a || addr == blocked_b) begin
               r.status = STATUS_BLOCKED;
            end else begin
               r.status = STATUS_OK;
            end
         end
         if (r.status == STATUS_TOO_SHORT || r.status == STATUS_BAD_SEPARATOR ||
             r.status == STATUS_BAD_DIGIT) begin
            r.mac = '0;
         end else begin
            r.mac = addr;
         end
         parsed_q.push_back(r);
         clear_parse();
      end
   endtask

   task automatic check_result(input logic [RSP_TDATA_WIDTH-1:0] data);
      parsed_mac_type want;
      if (parsed_q.size() == 0) begin
         report("unexpected transaction", 64'(data), '0);
         return;
      end
      want = parsed_q.pop_front();
      if (data[MAC_WIDTH-1:0] !== want.mac) begin
         report("mac_address", 64'(data[MAC_WIDTH-1:0]), 64'(want.mac));
      end
      if (data[MAC_WIDTH +: STATUS_WIDTH] !== want.status) begin
         report("status", 64'(data[MAC_WIDTH +: STATUS_WIDTH]), 64'(want.status));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         blocked_a = BLOCKED_A_RESET;
         blocked_b = BLOCKED_B_RESET;
         parsed_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_BLOCKED_A) begin
               blocked_a = csr_pwdata[MAC_WIDTH-1:0];
            end else if (csr_paddr == ADDR_BLOCKED_B) begin
               blocked_b = csr_pwdata[MAC_WIDTH-1:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            take_char(req_tdata, req_tlast);
         end
      end
      pending  <= parsed_q.size();
      failures <= mismatches;
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import macp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;   // [7:0] character
   logic                       req_tlast;   // end_of_string
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;   // [47:0] mac_address, [50:48] status
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   int                   failures;
   int                   pending;
   int unsigned          cycle_count = 0;
   int                   items_sent  = 0;
   int                   gap_odds    = 0;
   int                   stall_odds  = 0;
   logic [MAC_WIDTH-1:0] block_a_now = BLOCKED_A_RESET;
   logic [MAC_WIDTH-1:0] block_b_now = BLOCKED_B_RESET;
   logic [7:0]           text_buf[$];

   mac_address_text_parser_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mac_text_checker parse_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return "0" + 8'(n);
      end
      return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
   endfunction

   task automatic build_text(input logic [MAC_WIDTH-1:0] addr);
      text_buf.delete();
      for (int i = ADDRESS_BYTES - 1; i >= 0; i--) begin
         text_buf.push_back(hex_char(addr[8*i+4 +: 4]));
         text_buf.push_back(hex_char(addr[8*i +: 4]));
         if (i != 0) begin
            text_buf.push_back($urandom_range(0, 1) ? CHAR_COLON : CHAR_HYPHEN);
         end
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic last);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_char(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   task automatic send_literal(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
      send_text();
   endtask

   function automatic logic [7:0] odd_char();
      logic [7:0] near_miss[8];
      near_miss = '{"/", CHAR_COLON, ";", "@", "G", "g", CHAR_HYPHEN, " "};
      if ($urandom_range(0, 2) == 0) begin
         return near_miss[$urandom_range(0, 7)];
      end
      return 8'($urandom);
   endfunction

   task automatic send_random_string();
      logic [MAC_WIDTH-1:0] addr;
      int                   kind;
      int                   cut;
      kind = $urandom_range(0, 99);
      addr = MAC_WIDTH'({$urandom, $urandom});
      if ($urandom_range(0, 7) == 0) begin
         addr = $urandom_range(0, 1) ? block_a_now : block_b_now;
      end else if ($urandom_range(0, 2) == 0) begin
         addr[ADDR_BITS-8] = 1'b0;
      end
      build_text(addr);
      if (kind < 50) begin
         // well formed
      end else if (kind < 68) begin
         repeat ($urandom_range(1, 2)) text_buf[$urandom_range(0, TEXT_LEN - 1)] = odd_char();
      end else if (kind < 80) begin
         cut = $urandom_range(1, TEXT_LEN - 1);
         while (text_buf.size() > cut) void'(text_buf.pop_back());
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom));
      end else begin
         text_buf.delete();
         repeat ($urandom_range(1, 24)) text_buf.push_back(8'($urandom));
      end
      send_text();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [MAC_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= {CSR_PAD_WIDTH'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == CSR_IDX_BLOCKED_A) begin
         block_a_now = value;
      end else begin
         block_b_now = value;
      end
      @(posedge clock);
   endtask

   task automatic run_random(input int target);
      while (items_sent < target) send_random_string();
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the blocked addresses
      gap_odds   = 4;
      stall_odds = 4;
      send_literal("0A-fF:09-aB:cD:Ef");
      text_buf = '{8'h00};
      send_text();
      send_literal("G:");
      text_buf = '{8'hff};
      send_text();
      run_random(300);
      drain();

      write_csr(CSR_IDX_BLOCKED_A, '1);
      write_csr(CSR_IDX_BLOCKED_B, '0);
      gap_odds   = 3;
      stall_odds = 2;
      run_random(575);
      drain();

      write_csr(CSR_IDX_BLOCKED_A, MAC_WIDTH'({$urandom, $urandom}) & 48'hfeff_ffff_ffff);
      write_csr(CSR_IDX_BLOCKED_B, MAC_WIDTH'({$urandom, $urandom}) & 48'hfeff_ffff_ffff);
      gap_odds   = 0;
      stall_odds = 5;
      run_random(850);
      drain();

      write_csr(CSR_IDX_BLOCKED_A, MAC_WIDTH'({$urandom, $urandom}) & 48'hfeff_ffff_ffff);
      write_csr(CSR_IDX_BLOCKED_B, 48'hfeff_ffff_ffff);
      gap_odds   = 0;
      stall_odds = 0;
      run_random(1120);
      drain();

      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
